// ===== rtl/tbpd_pkg.sv =====
`timescale 1ns / 1ps

package tbpd_pkg;

  localparam int ANGLE_W    = 17;
  localparam int ERR_W      = 18;
  localparam int DER_W      = 19;
  localparam int SUM_W      = 32;
  localparam int GAIN_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int DUTY_W     = 9;
  localparam int PP_W       = GAIN_W + 1 + ERR_W;
  localparam int PI_W       = GAIN_W + 1 + SUM_W;
  localparam int PD_W       = GAIN_W + 1 + DER_W;
  localparam int ACC_W      = PI_W + 2;
  localparam int SHIFT      = 16;
  localparam int MAG_W      = ACC_W - SHIFT;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PWR = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CAP     = 3'd7;

  localparam logic [ANGLE_W-1:0] RST_TARGET  = 17'd0;
  localparam logic [GAIN_W-1:0]  RST_GAIN_P  = 16'd1280;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I  = 16'd0;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D  = 16'd128;
  localparam logic [GAIN_W-1:0]  RST_TILT    = 16'd11520;
  localparam logic [BYTE_W-1:0]  RST_NOISE   = 8'd5;
  localparam logic [BYTE_W-1:0]  RST_MIN_PWR = 8'd40;
  localparam logic [BYTE_W-1:0]  RST_CAP     = 8'd255;

  localparam logic [SUM_W-1:0] SUM_MAX = 32'h7fff_ffff;
  localparam logic [SUM_W-1:0] SUM_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] target;
    logic [GAIN_W-1:0]         gain_p;
    logic [GAIN_W-1:0]         gain_i;
    logic [GAIN_W-1:0]         gain_d;
    logic [GAIN_W-1:0]         tilt_limit;
    logic [BYTE_W-1:0]         noise_floor;
    logic [BYTE_W-1:0]         min_power;
    logic [BYTE_W-1:0]         duty_cap;
  } cfg_t;

  typedef struct packed {
    logic                    trip;
    logic signed [ERR_W-1:0] err;
    logic signed [SUM_W-1:0] esum;
    logic signed [DER_W-1:0] deriv;
  } stage1_t;

  typedef struct packed {
    logic                   trip;
    logic signed [PP_W-1:0] pp;
    logic signed [PI_W-1:0] pi;
    logic signed [PD_W-1:0] pd;
  } prod_t;

endpackage

// ===== rtl/tbpd_if.sv =====
`timescale 1ns / 1ps

interface tbpd_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tbpd_pkg::ANGLE_W-1:0]   angle;

  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

interface tbpd_out_if;
  logic                          valid;
  logic                          ready;
  logic [tbpd_pkg::DUTY_W-1:0]   duty;
  logic                          forward;
  logic                          tripped;

  modport source (output valid, output duty, output forward, output tripped, input ready);
  modport sink (input valid, input duty, input forward, input tripped, output ready);
endinterface

// ===== rtl/tilt_balance_pid_drive.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// in_chan   in   valid / ready      angle[16:0] signed
// out_chan  out  valid / ready      duty[8:0], forward, tripped
// cfg_*     in   cfg_we             cfg_index[2:0], cfg_wdata[16:0]
//
// one request per cycle sustained while out_chan is ready; a result is offered after every stage below
// stages: input reg, error/integral update, three multipliers, sum and duty shaping
// the integral and previous error are updated in the second stage, so items chain back to back
// synchronous active-low reset clears valids and state and sets config registers to defaults
// a stalled output holds its result; earlier stages keep filling until the pipe is full

module tilt_balance_pid_drive (
  input  logic                                clk,
  input  logic                                rst_n,
  tbpd_in_if.sink                             in_chan,
  tbpd_out_if.source                          out_chan,
  input  logic                                cfg_we,
  input  logic [tbpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tbpd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  tbpd_pkg::cfg_t     cfg_r;
  logic               s1_valid;
  tbpd_pkg::stage1_t  s1_data;
  logic               s1_ready;
  logic               s2_valid;
  tbpd_pkg::prod_t    s2_data;
  logic               s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target      <= tbpd_pkg::RST_TARGET;
      cfg_r.gain_p      <= tbpd_pkg::RST_GAIN_P;
      cfg_r.gain_i      <= tbpd_pkg::RST_GAIN_I;
      cfg_r.gain_d      <= tbpd_pkg::RST_GAIN_D;
      cfg_r.tilt_limit  <= tbpd_pkg::RST_TILT;
      cfg_r.noise_floor <= tbpd_pkg::RST_NOISE;
      cfg_r.min_power   <= tbpd_pkg::RST_MIN_PWR;
      cfg_r.duty_cap    <= tbpd_pkg::RST_CAP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tbpd_pkg::REG_TARGET:  cfg_r.target      <= cfg_wdata;
        tbpd_pkg::REG_GAIN_P:  cfg_r.gain_p      <= cfg_wdata[tbpd_pkg::GAIN_W-1:0];
        tbpd_pkg::REG_GAIN_I:  cfg_r.gain_i      <= cfg_wdata[tbpd_pkg::GAIN_W-1:0];
        tbpd_pkg::REG_GAIN_D:  cfg_r.gain_d      <= cfg_wdata[tbpd_pkg::GAIN_W-1:0];
        tbpd_pkg::REG_TILT:    cfg_r.tilt_limit  <= cfg_wdata[tbpd_pkg::GAIN_W-1:0];
        tbpd_pkg::REG_NOISE:   cfg_r.noise_floor <= cfg_wdata[tbpd_pkg::BYTE_W-1:0];
        tbpd_pkg::REG_MIN_PWR: cfg_r.min_power   <= cfg_wdata[tbpd_pkg::BYTE_W-1:0];
        tbpd_pkg::REG_CAP:     cfg_r.duty_cap    <= cfg_wdata[tbpd_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  tbpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg      (cfg_r),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .s1_ready (s1_ready)
  );

  tbpd_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .s1_ready (s1_ready),
    .s2_valid (s2_valid),
    .s2_data  (s2_data),
    .s2_ready (s2_ready)
  );

  tbpd_shape u_shape (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .s2_valid (s2_valid),
    .s2_data  (s2_data),
    .s2_ready (s2_ready),
    .out_chan (out_chan)
  );

endmodule

// ===== rtl/tbpd_front.sv =====
`timescale 1ns / 1ps

module tbpd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  tbpd_in_if.sink               in_chan,
  input  tbpd_pkg::cfg_t        cfg,
  output logic                  s1_valid,
  output tbpd_pkg::stage1_t     s1_data,
  input  logic                  s1_ready
);

  logic                                  s0_v_r;
  logic signed [tbpd_pkg::ANGLE_W-1:0]   s0_angle_r;
  logic                                  s1_v_r;
  tbpd_pkg::stage1_t                     s1_r;
  logic signed [tbpd_pkg::SUM_W-1:0]     esum_r;
  logic signed [tbpd_pkg::SUM_W-1:0]     esum_nxt;
  logic signed [tbpd_pkg::ERR_W-1:0]     last_err_r;

  logic                                  s1_adv;
  logic                                  fire;
  logic [tbpd_pkg::ANGLE_W-1:0]          ang_mag;
  logic                                  trip;
  logic signed [tbpd_pkg::ERR_W-1:0]     err;
  logic signed [tbpd_pkg::DER_W-1:0]     deriv;
  logic [tbpd_pkg::SUM_W:0]              acc;
  logic [tbpd_pkg::SUM_W-1:0]            acc_sat;

  assign s1_adv        = !s1_v_r || s1_ready;
  assign fire          = s0_v_r && s1_adv;
  assign in_chan.ready = !s0_v_r || s1_adv;

  always_comb begin
    ang_mag = s0_angle_r[tbpd_pkg::ANGLE_W-1] ? (~s0_angle_r + 1'b1) : s0_angle_r;
    trip    = ang_mag > {1'b0, cfg.tilt_limit};
    err     = {cfg.target[tbpd_pkg::ANGLE_W-1], cfg.target}
            - {s0_angle_r[tbpd_pkg::ANGLE_W-1], s0_angle_r};
    deriv   = {err[tbpd_pkg::ERR_W-1], err} - {last_err_r[tbpd_pkg::ERR_W-1], last_err_r};
    acc     = {esum_r[tbpd_pkg::SUM_W-1], esum_r}
            + {{(tbpd_pkg::SUM_W + 1 - tbpd_pkg::ERR_W){err[tbpd_pkg::ERR_W-1]}}, err};
    // saturate on signed overflow of the integral
    if (acc[tbpd_pkg::SUM_W] != acc[tbpd_pkg::SUM_W-1]) begin
      acc_sat = acc[tbpd_pkg::SUM_W] ? tbpd_pkg::SUM_MIN : tbpd_pkg::SUM_MAX;
    end else begin
      acc_sat = acc[tbpd_pkg::SUM_W-1:0];
    end
    esum_nxt = trip ? '0 : acc_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r     <= 1'b0;
      s1_v_r     <= 1'b0;
      esum_r     <= '0;
      last_err_r <= '0;
    end else begin
      if (in_chan.ready) begin
        s0_v_r <= in_chan.valid;
      end
      if (s1_adv) begin
        s1_v_r <= s0_v_r;
      end
      if (fire) begin
        esum_r <= esum_nxt;
        if (!trip) begin
          last_err_r <= err;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s0_angle_r <= in_chan.angle;
    end
    if (fire) begin
      s1_r.trip  <= trip;
      s1_r.err   <= err;
      s1_r.esum  <= esum_nxt;
      s1_r.deriv <= deriv;
    end
  end

  assign s1_valid = s1_v_r;
  assign s1_data  = s1_r;

  a_trip_clears_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && trip) |=> (esum_r == '0))
    else $error("integral not cleared on tilt trip");

  a_trip_keeps_err: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && trip) |=> $stable(last_err_r))
    else $error("previous error changed on tilt trip");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> ($stable(esum_r) && $stable(last_err_r)))
    else $error("controller state moved without a request");

  a_sum_forwarded: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (s1_r.esum == esum_r))
    else $error("stage integral differs from state");

endmodule

// ===== rtl/tbpd_mult.sv =====
`timescale 1ns / 1ps

module tbpd_mult (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tbpd_pkg::cfg_t        cfg,
  input  logic                  s1_valid,
  input  tbpd_pkg::stage1_t     s1_data,
  output logic                  s1_ready,
  output logic                  s2_valid,
  output tbpd_pkg::prod_t       s2_data,
  input  logic                  s2_ready
);

  logic                                s2_v_r;
  tbpd_pkg::prod_t                     s2_r;
  logic                                s2_adv;
  logic signed [tbpd_pkg::ERR_W-1:0]   err;
  logic signed [tbpd_pkg::SUM_W-1:0]   esum;
  logic signed [tbpd_pkg::DER_W-1:0]   deriv;
  logic signed [tbpd_pkg::PP_W-1:0]    pp;
  logic signed [tbpd_pkg::PI_W-1:0]    pi;
  logic signed [tbpd_pkg::PD_W-1:0]    pd;

  assign s2_adv   = !s2_v_r || s2_ready;
  assign s1_ready = s2_adv;

  assign err   = s1_data.err;
  assign esum  = s1_data.esum;
  assign deriv = s1_data.deriv;

  assign pp = $signed({1'b0, cfg.gain_p}) * err;
  assign pi = $signed({1'b0, cfg.gain_i}) * esum;
  assign pd = $signed({1'b0, cfg.gain_d}) * deriv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_adv) begin
      s2_v_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid) begin
      s2_r.trip <= s1_data.trip;
      s2_r.pp   <= pp;
      s2_r.pi   <= pi;
      s2_r.pd   <= pd;
    end
  end

  assign s2_valid = s2_v_r;
  assign s2_data  = s2_r;

endmodule

// ===== rtl/tbpd_shape.sv =====
`timescale 1ns / 1ps

module tbpd_shape (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tbpd_pkg::cfg_t        cfg,
  input  logic                  s2_valid,
  input  tbpd_pkg::prod_t       s2_data,
  output logic                  s2_ready,
  tbpd_out_if.source            out_chan
);

  logic                               out_v_r;
  logic [tbpd_pkg::DUTY_W-1:0]        duty_r;
  logic                               fwd_r;
  logic                               trip_r;
  logic                               s3_adv;

  logic [tbpd_pkg::ACC_W-1:0]         sum;
  logic [tbpd_pkg::ACC_W-1:0]         sum_abs;
  logic [tbpd_pkg::MAG_W-1:0]         mag;
  logic [tbpd_pkg::BYTE_W-1:0]        pwm;
  logic [tbpd_pkg::DUTY_W-1:0]        duty_nxt;
  logic                               fwd_nxt;

  assign s3_adv   = !out_v_r || out_chan.ready;
  assign s2_ready = s3_adv;

  always_comb begin
    sum = {{(tbpd_pkg::ACC_W - tbpd_pkg::PP_W){s2_data.pp[tbpd_pkg::PP_W-1]}}, s2_data.pp}
        + {{(tbpd_pkg::ACC_W - tbpd_pkg::PI_W){s2_data.pi[tbpd_pkg::PI_W-1]}}, s2_data.pi}
        + {{(tbpd_pkg::ACC_W - tbpd_pkg::PD_W){s2_data.pd[tbpd_pkg::PD_W-1]}}, s2_data.pd};
    sum_abs = sum[tbpd_pkg::ACC_W-1] ? (~sum + 1'b1) : sum;
    mag     = sum_abs[tbpd_pkg::ACC_W-1:tbpd_pkg::SHIFT];
    fwd_nxt = !sum[tbpd_pkg::ACC_W-1] && (sum != '0);
    if (mag > {{(tbpd_pkg::MAG_W - tbpd_pkg::BYTE_W){1'b0}}, cfg.duty_cap}) begin
      pwm = cfg.duty_cap;
    end else begin
      pwm = mag[tbpd_pkg::BYTE_W-1:0];
    end
    // deadzone offset, below the noise floor gives zero
    if (pwm < cfg.noise_floor) begin
      duty_nxt = '0;
    end else begin
      duty_nxt = {1'b0, pwm} + {1'b0, cfg.min_power};
    end
    if (s2_data.trip) begin
      duty_nxt = '0;
      fwd_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s3_adv) begin
      out_v_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv && s2_valid) begin
      duty_r <= duty_nxt;
      fwd_r  <= fwd_nxt;
      trip_r <= s2_data.trip;
    end
  end

  assign out_chan.valid   = out_v_r;
  assign out_chan.duty    = duty_r;
  assign out_chan.forward = fwd_r;
  assign out_chan.tripped = trip_r;

endmodule
